// ===== hw/rtl/i2ew_pkg.sv =====
package i2ew_pkg;

  // input and digit sizes
  localparam int ValueW = 31;
  localparam int Digits = 10;
  localparam int BcdW   = 4 * Digits;
  localparam int GroupW = 12;
  localparam int SpellW = 4 * GroupW;
  localparam int CntW   = $clog2(ValueW);
  localparam int WordW  = 5;

  // word codes
  localparam logic [WordW-1:0] WordZero    = 5'd0;
  localparam logic [WordW-1:0] WordTen     = 5'd10;
  localparam logic [WordW-1:0] WordTwenty  = 5'd20;
  localparam logic [WordW-1:0] WordHundred = 5'd28;
  localparam logic [WordW-1:0] WordBillion = 5'd31;

  // group indexes, most significant first
  localparam logic [1:0] GrpUnits = 2'd3;

  // steps of the group speller
  localparam logic [2:0] PhHundDigit = 3'd0;
  localparam logic [2:0] PhHundred   = 3'd1;
  localparam logic [2:0] PhTens      = 3'd2;
  localparam logic [2:0] PhOnes      = 3'd3;
  localparam logic [2:0] PhScale     = 3'd4;

  // sequencer view handed to the speller
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] grp;
    logic       lower_zero;
  } spell_ctl_t;

  // word the speller offers at the current step
  typedef struct packed {
    logic             emit;
    logic [WordW-1:0] word;
    logic             last;
  } word_tok_t;

  // true when every bcd digit is 0..9
  function automatic logic bcd_ok(input logic [BcdW-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < Digits; i++) begin
      if (bcd[4*i +: 4] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== hw/rtl/i2ew_dabble.sv =====
module i2ew_dabble (
  input  logic [i2ew_pkg::BcdW-1:0] bcd_i,
  input  logic                      bit_i,
  output logic [i2ew_pkg::BcdW-1:0] bcd_o
);
  import i2ew_pkg::*;

  logic [BcdW-1:0] adj;

  // add three to every digit of five or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      adj[4*i +: 4] = (bcd_i[4*i +: 4] >= 4'd5) ? bcd_i[4*i +: 4] + 4'd3
                                                 : bcd_i[4*i +: 4];
    end
  end

  assign bcd_o = {adj[BcdW-2:0], bit_i};

endmodule

// ===== hw/rtl/i2ew_speller.sv =====
module i2ew_speller (
  input  logic [i2ew_pkg::GroupW-1:0] group_i,
  input  i2ew_pkg::spell_ctl_t        ctl_i,
  output i2ew_pkg::word_tok_t         tok_o
);
  import i2ew_pkg::*;

  logic [3:0] hund;
  logic [3:0] tens;
  logic [3:0] ones;
  logic       has_scale;

  assign hund = group_i[11:8];
  assign tens = group_i[7:4];
  assign ones = group_i[3:0];

  // a scale word follows every nonzero group above the units
  assign has_scale = (ctl_i.grp != GrpUnits) && (group_i != '0);

  // pick the word for this step and whether nothing follows it
  always_comb begin
    tok_o = '0;
    unique case (ctl_i.phase)
      PhHundDigit: begin
        tok_o.emit = hund != 4'd0;
        tok_o.word = {1'b0, hund};
        tok_o.last = 1'b0;
      end
      PhHundred: begin
        tok_o.emit = hund != 4'd0;
        tok_o.word = WordHundred;
        tok_o.last = (tens == 4'd0) && (ones == 4'd0) && !has_scale && ctl_i.lower_zero;
      end
      PhTens: begin
        tok_o.emit = tens >= 4'd2;
        tok_o.word = WordTwenty + {1'b0, tens} - 5'd2;
        tok_o.last = (ones == 4'd0) && !has_scale && ctl_i.lower_zero;
      end
      PhOnes: begin
        if (tens == 4'd1) begin
          tok_o.emit = 1'b1;
          tok_o.word = WordTen + {1'b0, ones};
        end else begin
          tok_o.emit = ones != 4'd0;
          tok_o.word = {1'b0, ones};
        end
        tok_o.last = !has_scale && ctl_i.lower_zero;
      end
      PhScale: begin
        tok_o.emit = has_scale;
        tok_o.word = WordBillion - {3'b000, ctl_i.grp};
        tok_o.last = ctl_i.lower_zero;
      end
      default: tok_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/integer_to_english_word_tokens.sv =====
// Spells a 31-bit unsigned integer as English word codes, most significant
// first, one code per output request, with last_word_o set on the final one.
// Each number first runs through a shift-and-add-three binary to
// decimal converter, then a sequencer walks the billion, million, thousand
// and units groups in five steps each (hundreds digit, Hundred, tens, ones,
// scale word; the units group has no scale step), taking every step whether
// or not it has a word, holding a step whose word finds the output register
// full and stalled, and stopping at the final word. in_stall_o is high from
// acceptance until the last word has been placed in the output register,
// which can still be waiting to be taken when the next request comes in.
module integer_to_english_word_tokens (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [i2ew_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [i2ew_pkg::WordW-1:0]    word_o,
  output logic                          last_word_o
);
  import i2ew_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StConv  = 2'd1;
  localparam logic [1:0] StSpell = 2'd2;
  localparam logic [1:0] StZero  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        phase_q, phase_d;
  logic [1:0]        grp_q, grp_d;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] bin_q, bin_d;
  logic [SpellW-1:0] bcd_q, bcd_d;
  logic [WordW-1:0]  word_q, word_d;
  logic              last_q, last_d;

  logic [BcdW-1:0]   dab;
  spell_ctl_t        ctl;
  word_tok_t         tok;
  logic              out_free;

  // binary to decimal step used while converting
  i2ew_dabble u_dabble (
    .bcd_i (bcd_q[BcdW-1:0]),
    .bit_i (bin_q[ValueW-1]),
    .bcd_o (dab)
  );

  // word choice for the current group and step
  assign ctl.phase      = phase_q;
  assign ctl.grp        = grp_q;
  assign ctl.lower_zero = bcd_q[SpellW-GroupW-1:0] == '0;

  i2ew_speller u_speller (
    .group_i (bcd_q[SpellW-1 -: GroupW]),
    .ctl_i   (ctl),
    .tok_o   (tok)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    grp_d       = grp_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    word_d      = word_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          bin_d   = value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = (value_i == '0) ? StZero : StConv;
        end
      end
      StConv: begin
        bcd_d = {{(SpellW-BcdW){1'b0}}, dab};
        bin_d = {bin_q[ValueW-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(ValueW - 1)) begin
          state_d = StSpell;
          phase_d = PhHundDigit;
          grp_d   = '0;
        end
      end
      StSpell: begin
        if (!tok.emit || out_free) begin
          if (tok.emit) begin
            out_valid_d = 1'b1;
            word_d      = tok.word;
            last_d      = tok.last;
          end
          if (tok.emit && tok.last) begin
            state_d = StIdle;
          end else if (phase_q == PhScale || (phase_q == PhOnes && grp_q == GrpUnits)) begin
            phase_d = PhHundDigit;
            grp_d   = grp_q + 2'd1;
            bcd_d   = {bcd_q[SpellW-GroupW-1:0], {GroupW{1'b0}}};
          end else begin
            phase_d = phase_q + 3'd1;
          end
        end
      end
      StZero: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          word_d      = WordZero;
          last_d      = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      phase_q     <= PhHundDigit;
      grp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      grp_q       <= grp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    word_q <= word_d;
    last_q <= last_d;
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign last_word_o = last_q;

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == StConv || state_q == StZero)
    else $error("accepted request did not start work");

  // conversion counter stays within the input width
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StConv |-> cnt_q < CntW'(ValueW))
    else $error("conversion counter overran");

  // decimal digits stay legal while converting
  a_bcd_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StConv |-> bcd_ok(bcd_q[BcdW-1:0]))
    else $error("illegal decimal digit");

  // handing out the final word ends the number
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSpell && tok.emit && tok.last && out_free |=> state_q == StIdle && last_q)
    else $error("final word did not end the number");

  // spelling never runs past the units group
  a_grp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSpell && grp_q == GrpUnits && phase_q == PhOnes |-> tok.emit && tok.last)
    else $error("units group finished without a final word");

endmodule

// ===== dv/integer_to_english_word_tokens_tb.sv =====
`timescale 1ns / 100ps

module integer_to_english_word_tokens_tb;
  import i2ew_pkg::*;

  // scale words with no constant in the package
  localparam logic [WordW-1:0] WordThousand = 5'd29;
  localparam logic [WordW-1:0] WordMillion  = 5'd30;

  localparam int unsigned ValueMax = 32'h7FFF_FFFF;
  // cycles past the last word: conversion plus group walk of one number
  localparam int DrainCycles = 60;
  localparam int WatchdogLimit = 1000;
  localparam int MaxErrorPrints = 100;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } word_exp_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [ValueW-1:0] value_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [WordW-1:0]  word_o;
  logic              last_word_o;

  // idle rates of the two sides, in percent
  int unsigned send_gap_pct  = 0;
  int unsigned out_stall_pct = 0;

  word_exp_t        pending_words[$];
  logic [WordW-1:0] spelled[$];
  int               error_cnt = 0;
  int               idle_cycles = 0;

  integer_to_english_word_tokens dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (word_o),
    .last_word_o (last_word_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // spell one group of 0..999 into the scratch list
  function automatic void add_group(input int unsigned n);
    if (n >= 100) begin
      spelled.push_back(WordW'(n / 100));
      spelled.push_back(WordHundred);
      n = n % 100;
    end
    if (n >= 20) begin
      spelled.push_back(WordTwenty + WordW'(n / 10 - 2));
      n = n % 10;
    end
    if (n > 0) spelled.push_back(WordW'(n));
  endfunction

  // expected word sequence of one accepted number
  function automatic void spell_number(input int unsigned v);
    int unsigned g;
    spelled.delete();
    if (v == 0) begin
      spelled.push_back(WordZero);
    end else begin
      g = v / 1000000000;
      if (g != 0) begin
        add_group(g);
        spelled.push_back(WordBillion);
      end
      g = (v / 1000000) % 1000;
      if (g != 0) begin
        add_group(g);
        spelled.push_back(WordMillion);
      end
      g = (v / 1000) % 1000;
      if (g != 0) begin
        add_group(g);
        spelled.push_back(WordThousand);
      end
      add_group(v % 1000);
    end
    foreach (spelled[i]) begin
      pending_words.push_back(word_exp_t'{spelled[i], i == spelled.size() - 1});
    end
  endfunction

  // random group value, weighted toward word boundaries
  function automatic int unsigned rand_group();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(1, 19);
      2: return $urandom_range(20, 99);
      3: return $urandom_range(1, 9) * 100;
      4: return $urandom_range(1, 9) * 100 + $urandom_range(1, 19);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  // send one request, with random idle cycles ahead of it
  task automatic send_value(input int unsigned v);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= ValueW'(v);
    do @(posedge clk_i); while (in_stall_o);
    spell_number(v);
  endtask

  // hold off the sender until every expected word has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // word checker and watchdog
  always @(posedge clk_i) begin
    word_exp_t exp_w;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
          $display("status: fail");
          $finish;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          error_cnt = error_cnt + 1;
          if (error_cnt <= MaxErrorPrints)
            $error("unexpected word: word %0d last_word %0d", word_o, last_word_o);
        end else begin
          exp_w = pending_words.pop_front();
          if (word_o !== exp_w.word) begin
            error_cnt = error_cnt + 1;
            if (error_cnt <= MaxErrorPrints)
              $error("word: expected %0d, actual %0d", exp_w.word, word_o);
          end
          if (last_word_o !== exp_w.last) begin
            error_cnt = error_cnt + 1;
            if (error_cnt <= MaxErrorPrints)
              $error("last_word: expected %0d, actual %0d", exp_w.last, last_word_o);
          end
        end
      end
    end
  end

  // zero, field extremes, teens, tens, zero groups and the longest spelling
  task automatic test_special_values();
    int unsigned vals[] = '{0, 1, 7, 10, 11, 13, 19, 20, 21, 45, 90, 99, 100, 101, 118,
                            999, 1000, 1001, 1000000, 1000010, 1000000000, 1000000001,
                            1777777777, 2000000000, ValueMax};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // sender pauses until the block has emptied, then resumes
  task automatic test_drain_pause();
    send_value(1234567);
    send_value(ValueMax);
    wait_drained();
    send_value(0);
    send_value(1001001001);
  endtask

  // random numbers, half of them built group by group
  task automatic test_random_numbers(input int count);
    longint unsigned v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom() & ValueMax;
        1: v = $urandom_range(0, 999999);
        default: begin
          v = longint'($urandom_range(0, 2)) * 1000000000 +
              longint'(rand_group()) * 1000000 +
              longint'(rand_group()) * 1000 + rand_group();
          if (v > ValueMax) v = v - 1000000000;
        end
      endcase
      send_value(int'(v));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_values();
    test_drain_pause();

    // idle phases: none, sender gaps, receiver stalls, both light
    test_random_numbers(50);
    wait_drained();
    send_gap_pct = 53;
    test_random_numbers(50);
    wait_drained();
    send_gap_pct  = 0;
    out_stall_pct = 53;
    test_random_numbers(50);
    wait_drained();
    send_gap_pct  = 6;
    out_stall_pct = 6;
    test_random_numbers(50);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_cnt == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
